@@ hw/rtl/bbs_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, register codes, reset values and control structs for the
// Bollinger band stream unit. No dependencies.
package bbs_pkg;

  // Ring depth and derived index and count widths.
  localparam int MAX_WINDOW = 64;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int P_W        = $clog2(MAX_WINDOW + 1);

  // Field widths.
  localparam int PRICE_W = 24;
  localparam int X_W     = 16;
  localparam int WL_W    = 7;
  localparam int K_W     = 12;
  localparam int K_FRAC  = 8;

  // Arithmetic widths that follow from the window depth.
  localparam int SUM_W   = PRICE_W + PTR_W;
  localparam int SQ_W    = 2 * PRICE_W + PTR_W;
  localparam int VAR_W   = 2 * PRICE_W + 2 * PTR_W;
  localparam int ROOT_W  = VAR_W / 2;
  localparam int DIV_W   = (SUM_W > ROOT_W) ? SUM_W : ROOT_W;
  localparam int DELTA_W = K_W + ROOT_W - K_FRAC;

  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_BAND_FACTOR   = 1'b1;
  localparam logic [WL_W-1:0] WL_RESET = WL_W'(20);
  localparam logic [K_W-1:0]  K_RESET  = K_W'(512);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic acc_start;
    logic var_mul;
    logic var_sub;
    logic root_start;
    logic sd_start;
    logic band;
    logic emit;
  } bbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic window_full;
    logic acc_busy;
    logic root_busy;
    logic div_busy;
    logic out_free;
  } bbs_sts_t;

endpackage

@@ hw/rtl/bbs_stream_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample input and the band result.
// Depends on bbs_pkg for field widths.
interface bbs_in_if;
  logic                         valid;
  logic                         ready;
  logic [bbs_pkg::PRICE_W-1:0]  price;
  logic [bbs_pkg::X_W-1:0]      x_position;
  logic                         last_sample;

  modport source(output valid, price, x_position, last_sample, input ready);
  modport sink(input valid, price, x_position, last_sample, output ready);
endinterface

interface bbs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         band_valid;
  logic [bbs_pkg::PRICE_W-1:0]  middle_band;
  logic [bbs_pkg::PRICE_W-1:0]  upper_band;
  logic [bbs_pkg::PRICE_W-1:0]  lower_band;
  logic [bbs_pkg::X_W-1:0]      x_out;

  modport source(output valid, band_valid, middle_band, upper_band, lower_band, x_out,
                 input ready);
  modport sink(input valid, band_valid, middle_band, upper_band, lower_band, x_out,
               output ready);
endinterface

@@ hw/rtl/bbs_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, used for the mean and the
// standard deviation. Depends on bbs_pkg.
module bbs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bbs_pkg::DIV_W-1:0] dividend,
  input  logic [bbs_pkg::P_W-1:0]   divisor,
  output logic                      busy,
  output logic [bbs_pkg::DIV_W-1:0] quotient
);
  import bbs_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r;
  logic [P_W-1:0]   rem_r;
  logic [P_W-1:0]   dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic [P_W:0]     rem_sh;
  logic             q_bit;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    q_bit  = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // The dividend register turns into the quotient as bits shift through.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DIV_W-2:0], q_bit};
      rem_r <= q_bit ? P_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[P_W-1:0];
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

@@ hw/rtl/bbs_isqrt.sv @@
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on bbs_pkg.
module bbs_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bbs_pkg::VAR_W-1:0]  radicand,
  output logic                       busy,
  output logic [bbs_pkg::ROOT_W-1:0] root
);
  import bbs_pkg::*;

  localparam int RW    = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [VAR_W-1:0]  rad_r;
  logic [RW-1:0]     rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     trial;
  logic              r_bit;

  // Bring down the next two radicand bits and compare against 4*root + 1.
  always_comb begin
    rem_sh = {rem_r[RW-3:0], rad_r[VAR_W-1:VAR_W-2]};
    trial  = {root_r, 2'b01};
    r_bit  = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(ROOT_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      rad_r  <= {rad_r[VAR_W-3:0], 2'b00};
      rem_r  <= r_bit ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], r_bit};
    end
  end

  assign busy = (cnt_r != '0);
  assign root = root_r;

endmodule

@@ hw/rtl/bbs_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for one sample: accumulate, variance, root, divides, band, emit.
// Depends on bbs_pkg for the command and status structs.
module bbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output bbs_pkg::bbs_cmd_t cmd,
  input  bbs_pkg::bbs_sts_t sts
);
  import bbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ACC_GO,
    S_ACC_WAIT,
    S_VAR_MUL,
    S_VAR_SUB,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_SD_GO,
    S_SD_WAIT,
    S_BAND,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   fire;

  assign fire = in_valid && in_ready_r;

  // Next state; the input is open only while idle.
  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          state_nxt = S_CHECK;
        end else begin
          in_ready_nxt = 1'b1;
        end
      end
      S_CHECK:     state_nxt = sts.window_full ? S_ACC_GO : S_EMIT;
      S_ACC_GO:    state_nxt = S_ACC_WAIT;
      S_ACC_WAIT:  if (!sts.acc_busy) state_nxt = S_VAR_MUL;
      S_VAR_MUL:   state_nxt = S_VAR_SUB;
      S_VAR_SUB:   state_nxt = S_ROOT_GO;
      S_ROOT_GO:   state_nxt = S_ROOT_WAIT;
      S_ROOT_WAIT: if (!sts.root_busy && !sts.div_busy) state_nxt = S_SD_GO;
      S_SD_GO:     state_nxt = S_SD_WAIT;
      S_SD_WAIT:   if (!sts.div_busy) state_nxt = S_BAND;
      S_BAND:      state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  // Commands decode from the current state.
  always_comb begin
    cmd            = '0;
    cmd.load       = fire;
    cmd.acc_start  = (state_r == S_ACC_GO);
    cmd.var_mul    = (state_r == S_VAR_MUL);
    cmd.var_sub    = (state_r == S_VAR_SUB);
    cmd.root_start = (state_r == S_ROOT_GO);
    cmd.sd_start   = (state_r == S_SD_GO);
    cmd.band       = (state_r == S_BAND);
    cmd.emit       = (state_r == S_EMIT) && sts.out_free;
  end

  assign in_ready = in_ready_r;

endmodule

@@ hw/rtl/bbs_dp.sv @@
`timescale 1ns / 1ps
// Datapath: sample ring, sum and square accumulator, variance, root and
// divide units, band arithmetic and the result register. Depends on bbs_pkg,
// bbs_stream_if, bbs_isqrt and bbs_div.
module bbs_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [bbs_pkg::WL_W-1:0] window_length,
  input  logic [bbs_pkg::K_W-1:0]  band_width_factor,
  bbs_in_if.sink                   in_bus,
  bbs_out_if.source                out_bus,
  input  bbs_pkg::bbs_cmd_t        cmd,
  output bbs_pkg::bbs_sts_t        sts
);
  import bbs_pkg::*;

  localparam int CMP_W = (WL_W > P_W) ? WL_W + 1 : P_W + 1;

  // Sample ring and series bookkeeping.
  logic [PRICE_W-1:0] ring [MAX_WINDOW];
  logic [PTR_W-1:0]   wp_r;
  logic [PTR_W-1:0]   wp_item_r;
  logic [P_W-1:0]     fill_r;
  logic [P_W-1:0]     fill_nxt;
  logic [P_W-1:0]     p_eff;
  logic [P_W-1:0]     p_r;
  logic [K_W-1:0]     k_r;
  logic [X_W-1:0]     x_r;
  logic               full_r;

  // Accumulator pipeline.
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [P_W-1:0]       issue_cnt_r;
  logic [PRICE_W-1:0]   rd_data_r;
  logic                 v1_r;
  logic                 v2_r;
  logic [PRICE_W-1:0]   s_r;
  logic [2*PRICE_W-1:0] sq_r;
  logic [2*PRICE_W-1:0] sq_prod;
  logic [SUM_W-1:0]     sum_r;
  logic [SQ_W-1:0]      sumsq_r;

  // Variance, root, divides and band.
  logic [P_W+SQ_W-1:0]   pss_prod;
  logic [2*SUM_W-1:0]    ss_prod;
  logic [VAR_W-1:0]      pss_r;
  logic [VAR_W-1:0]      ss_r;
  logic [VAR_W-1:0]      var_r;
  logic [ROOT_W-1:0]     root;
  logic                  root_busy;
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      quotient;
  logic                  div_busy;
  logic [PRICE_W-1:0]    mean_r;
  logic [K_W+ROOT_W-1:0] k_prod;
  logic [DELTA_W-1:0]    delta_r;
  logic [DELTA_W:0]      up_sum;
  logic [PRICE_W-1:0]    upper;
  logic [PRICE_W-1:0]    lower;

  // Result register.
  logic               out_valid_r;
  logic               band_valid_r;
  logic [PRICE_W-1:0] middle_r;
  logic [PRICE_W-1:0] upper_r;
  logic [PRICE_W-1:0] lower_r;
  logic [X_W-1:0]     x_out_r;

  // Effective window length: zero counts as one, long windows clamp to the ring.
  always_comb begin
    if (window_length == '0) begin
      p_eff = P_W'(1);
    end else if (CMP_W'(window_length) > CMP_W'(MAX_WINDOW)) begin
      p_eff = P_W'(MAX_WINDOW);
    end else begin
      p_eff = P_W'(window_length);
    end
    fill_nxt = (fill_r == P_W'(MAX_WINDOW)) ? fill_r : fill_r + 1'b1;
  end

  // Bookkeeping for each accepted beat; a series end rewinds the ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (cmd.load) begin
      if (in_bus.last_sample) begin
        wp_r   <= '0;
        fill_r <= '0;
      end else begin
        wp_r   <= (wp_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wp_item_r <= wp_r;
      p_r       <= p_eff;
      k_r       <= band_width_factor;
      x_r       <= in_bus.x_position;
      full_r    <= (fill_nxt >= p_eff);
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring[wp_r] <= in_bus.price;
    end
    rd_data_r <= ring[rd_ptr_r];
  end

  // Read the last p samples newest first; the read pointer walks backward.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_cnt_r <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else if (cmd.acc_start) begin
      issue_cnt_r <= p_r;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      v1_r <= (issue_cnt_r != '0);
      v2_r <= v1_r;
      if (issue_cnt_r != '0) begin
        issue_cnt_r <= issue_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_start) begin
      rd_ptr_r <= wp_item_r;
    end else if (issue_cnt_r != '0) begin
      rd_ptr_r <= (rd_ptr_r == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_ptr_r - 1'b1;
    end
  end

  // Square each sample, then add into the running sums.
  assign sq_prod = rd_data_r * rd_data_r;

  always_ff @(posedge clk) begin
    s_r  <= rd_data_r;
    sq_r <= sq_prod;
    if (cmd.acc_start) begin
      sum_r   <= '0;
      sumsq_r <= '0;
    end else if (v2_r) begin
      sum_r   <= sum_r + SUM_W'(s_r);
      sumsq_r <= sumsq_r + SQ_W'(sq_r);
    end
  end

  // Variance numerator p*sumsq - sum^2, products registered before the subtract.
  assign pss_prod = p_r * sumsq_r;
  assign ss_prod  = sum_r * sum_r;

  always_ff @(posedge clk) begin
    if (cmd.var_mul) begin
      pss_r <= pss_prod[VAR_W-1:0];
      ss_r  <= VAR_W'(ss_prod);
    end
    if (cmd.var_sub) begin
      var_r <= pss_r - ss_r;
    end
  end

  bbs_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand (var_r),
    .busy     (root_busy),
    .root     (root)
  );

  // The divider first forms the mean, then the root over p.
  assign div_start    = cmd.root_start || cmd.sd_start;
  assign div_dividend = cmd.sd_start ? DIV_W'(root) : DIV_W'(sum_r);

  bbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (p_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Band offset k * stddev with k in Q4.8, fraction dropped.
  assign k_prod = k_r * ROOT_W'(quotient);

  always_ff @(posedge clk) begin
    if (cmd.sd_start) begin
      mean_r <= quotient[PRICE_W-1:0];
    end
    if (cmd.band) begin
      delta_r <= k_prod[K_W+ROOT_W-1:K_FRAC];
    end
  end

  // Saturate the upper band at full scale and the lower band at zero.
  always_comb begin
    up_sum = (DELTA_W + 1)'(mean_r) + (DELTA_W + 1)'(delta_r);
    upper  = (up_sum > (DELTA_W + 1)'(PRICE_MAX)) ? PRICE_MAX : up_sum[PRICE_W-1:0];
    lower  = (delta_r >= DELTA_W'(mean_r)) ? '0 : mean_r - delta_r[PRICE_W-1:0];
  end

  // Result register holds one beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      band_valid_r <= full_r;
      middle_r     <= full_r ? mean_r : '0;
      upper_r      <= full_r ? upper : '0;
      lower_r      <= full_r ? lower : '0;
      x_out_r      <= x_r;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.band_valid  = band_valid_r;
  assign out_bus.middle_band = middle_r;
  assign out_bus.upper_band  = upper_r;
  assign out_bus.lower_band  = lower_r;
  assign out_bus.x_out       = x_out_r;

  always_comb begin
    sts             = '0;
    sts.window_full = full_r;
    sts.acc_busy    = (issue_cnt_r != '0) || v1_r || v2_r;
    sts.root_busy   = root_busy;
    sts.div_busy    = div_busy;
    sts.out_free    = !out_valid_r || out_bus.ready;
  end

endmodule

@@ hw/rtl/bollinger_band_stream_unit.sv @@
`timescale 1ns / 1ps
// Bollinger band stream unit: moving average with a standard deviation envelope.
// Usage:
//   in_bus carries one price beat (price Q16.8, x_position, last_sample) with
//   valid/ready. out_bus returns exactly one result beat per input beat:
//   band_valid, middle_band, upper_band, lower_band and x_out.
//   The APB port sets window_length (address 0) and band_width_factor
//   (address 4); write it only while no beat is in flight.
//   One beat is processed at a time. With a full window the unit reads and
//   sums the last p samples of the ring, p the window length, then runs the
//   square root with the mean divide beside it, then divides out the deviation;
//   the rest is sequencing. With the window not yet full the band arithmetic
//   is skipped and the result is loaded with band_valid low.
//   in_bus.ready rises the cycle after the result is loaded into the output
//   register, so a new beat is taken while that result waits.
//   A stalled receiver holds the result; a second result waits inside.
//   Synchronous reset empties the window and sets window_length to 20 and
//   band_width_factor to 512. The ring needs no clearing pass.
module bollinger_band_stream_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  bbs_in_if.sink                     in_bus,
  bbs_out_if.source                  out_bus,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bbs_pkg::CFG_AW-1:0] paddr,
  input  logic [bbs_pkg::CFG_DW-1:0] pwdata,
  output logic [bbs_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import bbs_pkg::*;

  logic [WL_W-1:0] wl_r;
  logic [K_W-1:0]  k_r;
  logic            reg_idx;
  bbs_cmd_t        cmd;
  bbs_sts_t        sts;
  logic            in_ready;

  // Configuration registers, decoded on the word index.
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= WL_RESET;
      k_r  <= K_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WINDOW_LENGTH: wl_r <= pwdata[WL_W-1:0];
        REG_BAND_FACTOR:   k_r  <= pwdata[K_W-1:0];
        default:           wl_r <= wl_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_LENGTH: prdata = CFG_DW'(wl_r);
      REG_BAND_FACTOR:   prdata = CFG_DW'(k_r);
      default:           prdata = '0;
    endcase
  end

  bbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  assign in_bus.ready = in_ready;

  bbs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .window_length     (wl_r),
    .band_width_factor (k_r),
    .in_bus            (in_bus),
    .out_bus           (out_bus),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bollinger_band_stream_unit: directed and random price beats
// checked against an internal band predictor. Depends on bbs_pkg, the bbs_in_if and bbs_out_if
// interfaces and the unit itself.
module tb;
  import bbs_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 900;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic               band_valid;
    logic [PRICE_W-1:0] middle;
    logic [PRICE_W-1:0] upper;
    logic [PRICE_W-1:0] lower;
    logic [X_W-1:0]     x_out;
  } band_point_t;

  logic clk = 1'b0;
  logic rst_n;

  bbs_in_if  samples();
  bbs_out_if bands();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Predictor state: price history, write slot and fill level, plus register copies.
  logic [PRICE_W-1:0] price_hist [MAX_WINDOW];
  int unsigned        wr_slot = 0;
  int unsigned        fill_level = 0;
  logic [WL_W-1:0]    wl_shadow = WL_RESET;
  logic [K_W-1:0]     k_shadow = K_RESET;

  band_point_t pending_bands [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  bollinger_band_stream_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (samples),
    .out_bus(bands),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One line per mismatch, and the count that decides the verdict.
  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    mismatch_count++;
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
  endtask

  // Computes the band point for one accepted beat and advances the predictor state.
  function automatic band_point_t predict_band(input logic [PRICE_W-1:0] price,
                                               input logic [X_W-1:0] xpos, input logic last);
    band_point_t        r;
    int unsigned        per;
    int unsigned        j;
    int unsigned        slot;
    int                 b;
    longint unsigned    s;
    longint unsigned    sum;
    longint unsigned    sumsq;
    longint unsigned    spread;
    longint unsigned    root;
    longint unsigned    cand;
    longint unsigned    dev;
    longint unsigned    delta;
    longint unsigned    mean;
    longint unsigned    up;
    if (wl_shadow == '0) begin
      per = 1;
    end else if (wl_shadow > MAX_WINDOW) begin
      per = MAX_WINDOW;
    end else begin
      per = 32'(wl_shadow);
    end
    slot = wr_slot;
    price_hist[slot] = price;
    if (fill_level < MAX_WINDOW) fill_level++;
    wr_slot = (slot + 1) % MAX_WINDOW;

    r = '0;
    r.x_out = xpos;
    if (fill_level >= per) begin
      sum = 0;
      sumsq = 0;
      for (j = 0; j < per; j++) begin
        s = 64'(price_hist[(slot + MAX_WINDOW - j) % MAX_WINDOW]);
        sum += s;
        sumsq += s * s;
      end
      spread = longint'(per) * sumsq - sum * sum;
      // Integer square root, one result bit at a time from the top.
      root = 0;
      for (b = 31; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= spread) root = cand;
      end
      dev = root / per;
      delta = (longint'(k_shadow) * dev) >> K_FRAC;
      mean = sum / per;
      up = mean + delta;
      if (up > PRICE_MAX) up = 64'(PRICE_MAX);
      r.band_valid = 1'b1;
      r.middle = mean[PRICE_W-1:0];
      r.upper = up[PRICE_W-1:0];
      r.lower = (delta >= mean) ? '0 : PRICE_W'(mean - delta);
    end
    if (last) begin
      wr_slot = 0;
      fill_level = 0;
    end
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      bands.ready <= 1'b0;
    end else begin
      bands.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result checker: every accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    band_point_t seen;
    band_point_t want;
    if (rst_n && bands.valid && bands.ready) begin
      seen = '{bands.band_valid, bands.middle_band, bands.upper_band, bands.lower_band,
               bands.x_out};
      if (pending_bands.size() == 0) begin
        report_mismatch("result beat with none expected", 64'd0, 64'(seen.x_out));
      end else begin
        want = pending_bands.pop_front();
        if (seen.band_valid !== want.band_valid)
          report_mismatch("band_valid", 64'(want.band_valid), 64'(seen.band_valid));
        if (seen.middle !== want.middle)
          report_mismatch("middle_band", 64'(want.middle), 64'(seen.middle));
        if (seen.upper !== want.upper)
          report_mismatch("upper_band", 64'(want.upper), 64'(seen.upper));
        if (seen.lower !== want.lower)
          report_mismatch("lower_band", 64'(want.lower), 64'(seen.lower));
        if (seen.x_out !== want.x_out)
          report_mismatch("x_out", 64'(want.x_out), 64'(seen.x_out));
      end
    end
  end

  // Watchdog: ends the run when no beat or register access completes for too long.
  always @(posedge clk) begin
    if ((samples.valid && samples.ready) || (bands.valid && bands.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Reads one register and checks it against the expected value.
  task automatic read_reg(input logic idx, input logic [CFG_DW-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_WINDOW_LENGTH) begin
      if (prdata[WL_W-1:0] !== want[WL_W-1:0])
        report_mismatch("window_length readback", 64'(want[WL_W-1:0]),
                        64'(prdata[WL_W-1:0]));
    end else begin
      if (prdata[K_W-1:0] !== want[K_W-1:0])
        report_mismatch("band_width_factor readback", 64'(want[K_W-1:0]),
                        64'(prdata[K_W-1:0]));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes one register, updates the predictor copy and reads the value back.
  task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_WINDOW_LENGTH) begin
      wl_shadow = value[WL_W-1:0];
    end else begin
      k_shadow = value[K_W-1:0];
    end
    read_reg(idx, value);
  endtask

  // Sends one price beat after an optional idle gap and records its expected band point.
  task automatic send_sample(input logic [PRICE_W-1:0] price, input logic [X_W-1:0] xpos,
                             input logic last);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      // Mostly short gaps; now and then a long one so gaps land deep inside the work.
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 160)) @(posedge clk);
      end else begin
        do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
      end
    end
    samples.valid <= 1'b1;
    samples.price <= price;
    samples.x_position <= xpos;
    samples.last_sample <= last;
    do @(posedge clk); while (!samples.ready);
    pending_bands.insert(pending_bands.size(), predict_band(price, xpos, last));
  endtask

  // Stops offering beats and waits until every expected result has arrived.
  task automatic wait_for_bands();
    samples.valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_register_defaults();
    read_reg(REG_WINDOW_LENGTH, CFG_DW'(WL_RESET));
    read_reg(REG_BAND_FACTOR, CFG_DW'(K_RESET));
  endtask

  // A window length of zero behaves as one: each beat is its own mean, no spread.
  task automatic test_single_sample_window();
    set_idling(0, 0);
    write_reg(REG_WINDOW_LENGTH, 32'd0);
    write_reg(REG_BAND_FACTOR, 32'd4095);
    send_sample(PRICE_MAX, 16'hFFFF, 1'b0);
    send_sample(24'h000000, 16'h0000, 1'b0);
    send_sample(24'h800000, 16'h5A5A, 1'b1);
    wait_for_bands();
  endtask

  // Widest spread saturates the upper band and clamps the lower band; series end clears.
  task automatic test_band_saturation();
    write_reg(REG_WINDOW_LENGTH, 32'd2);
    write_reg(REG_BAND_FACTOR, 32'd4095);
    send_sample(24'h000000, 16'h0001, 1'b0);
    send_sample(PRICE_MAX, 16'h8000, 1'b0);
    send_sample(PRICE_MAX, 16'h7FFF, 1'b1);
    send_sample(24'h000100, 16'h1234, 1'b0);
    send_sample(24'h000300, 16'h4321, 1'b1);
    wait_for_bands();
  endtask

  // Window length changes between beats of one series: shrink, grow, then beyond the ring.
  task automatic test_window_resize();
    write_reg(REG_WINDOW_LENGTH, 32'd4);
    write_reg(REG_BAND_FACTOR, 32'd256);
    send_sample(24'd1000, 16'd10, 1'b0);
    send_sample(24'd2000, 16'd11, 1'b0);
    send_sample(24'd3000, 16'd12, 1'b0);
    send_sample(24'd4000, 16'd13, 1'b0);
    wait_for_bands();
    write_reg(REG_WINDOW_LENGTH, 32'd2);
    send_sample(24'd5000, 16'd14, 1'b0);
    wait_for_bands();
    write_reg(REG_WINDOW_LENGTH, 32'd6);
    send_sample(24'd6000, 16'd15, 1'b0);
    wait_for_bands();
    write_reg(REG_WINDOW_LENGTH, 32'd127);
    send_sample(24'd7000, 16'd16, 1'b1);
    wait_for_bands();
  endtask

  // Random series over several settings and idling modes. Most series are long enough to
  // fill the window; some end early.
  task automatic test_random_series();
    int unsigned        phase;
    int unsigned        sent;
    int unsigned        target;
    int unsigned        per;
    int unsigned        series_left;
    int unsigned        style;
    logic [WL_W-1:0]    wl_pick;
    logic [K_W-1:0]     k_pick;
    logic [PRICE_W-1:0] base;
    logic [PRICE_W-1:0] price;
    series_left = 0;
    style = 0;
    base = '0;
    for (phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(63, 0);
        2: set_idling(0, 63);
        default: set_idling(30, 30);
      endcase
      case (phase)
        0: wl_pick = WL_RESET;
        1: wl_pick = 7'd1;
        2: wl_pick = 7'd64;
        3: wl_pick = 7'd0;
        4: wl_pick = 7'd127;
        default: wl_pick = WL_W'($urandom_range(2, 16));
      endcase
      case (phase)
        0: k_pick = K_RESET;
        1: k_pick = '0;
        2: k_pick = 12'd4095;
        default: k_pick = K_W'($urandom_range(0, 4095));
      endcase
      write_reg(REG_WINDOW_LENGTH, CFG_DW'(wl_pick));
      write_reg(REG_BAND_FACTOR, CFG_DW'(k_pick));
      per = (wl_pick == '0) ? 1 : ((wl_pick > MAX_WINDOW) ? MAX_WINDOW : 32'(wl_pick));
      target = (per >= 32) ? 180 : 105;
      for (sent = 0; sent < target; sent++) begin
        if (series_left == 0) begin
          if ($urandom_range(0, 4) == 0) begin
            series_left = $urandom_range(1, per);
          end else begin
            series_left = per + $urandom_range(0, 2 * per + 4);
          end
          style = $urandom_range(0, 3);
          base = PRICE_W'($urandom());
        end
        case (style)
          0: price = PRICE_W'($urandom());
          1: price = base ^ PRICE_W'($urandom_range(0, 511));
          2: price = $urandom_range(0, 1) ? PRICE_MAX : '0;
          default: price = PRICE_W'($urandom_range(0, 4095));
        endcase
        send_sample(price, X_W'($urandom()), series_left == 1);
        series_left--;
      end
      wait_for_bands();
    end
  endtask

  // Receiver holds off for a long stretch while beats keep coming, so the unit backs up.
  task automatic test_output_backpressure();
    int unsigned n;
    set_idling(0, 0);
    write_reg(REG_WINDOW_LENGTH, 32'd4);
    write_reg(REG_BAND_FACTOR, 32'd300);
    hold_req++;
    for (n = 0; n < 14; n++) begin
      send_sample(PRICE_W'($urandom()), X_W'($urandom()), n == 13);
    end
    wait_for_bands();
  endtask

  initial begin
    rst_n = 1'b0;
    samples.valid = 1'b0;
    samples.price = '0;
    samples.x_position = '0;
    samples.last_sample = 1'b0;
    bands.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_single_sample_window();
    test_band_saturation();
    test_window_resize();
    test_random_series();
    test_output_backpressure();

    // Let any stray result beat show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ bollinger_band_stream_unit.f @@
hw/rtl/bbs_pkg.sv
hw/rtl/bbs_stream_if.sv
hw/rtl/bbs_div.sv
hw/rtl/bbs_isqrt.sv
hw/rtl/bbs_ctrl.sv
hw/rtl/bbs_dp.sv
hw/rtl/bollinger_band_stream_unit.sv
tb/sv/tb.sv
